// ===== rtl/rhc_pkg.sv =====
`default_nettype none
package rhc_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FIELD_BITS       = 16;
    localparam int IN_TDATA_BITS    = 48;
    localparam int HUE_BITS         = 16;
    localparam int LIGHT_BITS       = 17;
    localparam int CLASS_BITS       = 3;
    localparam int OUT_TDATA_BITS   = 40;
    localparam int QUO_STEP_BITS    = 2;
    localparam int DIV_STAGES       = HUE_BITS / QUO_STEP_BITS;
    localparam int CFG_BITS         = 16;
    localparam int APB_DATA_BITS    = 32;
    localparam int APB_ADDR_BITS    = 5;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_WHITE   = 3'd0,
        CLS_BLACK   = 3'd1,
        CLS_RED     = 3'd2,
        CLS_MAGENTA = 3'd3,
        CLS_BLUE    = 3'd4,
        CLS_CYAN    = 3'd5,
        CLS_GREEN   = 3'd6,
        CLS_YELLOW  = 3'd7
    } t_class;

    typedef enum logic [2:0] {
        REG_WHITE_LEVEL     = 3'd0,
        REG_BLACK_LEVEL     = 3'd1,
        REG_RED_HUE_MIN     = 3'd2,
        REG_MAGENTA_HUE_MIN = 3'd3,
        REG_BLUE_HUE_MIN    = 3'd4,
        REG_CYAN_HUE_MIN    = 3'd5,
        REG_GREEN_HUE_MIN   = 3'd6,
        REG_YELLOW_HUE_MIN  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CFG_BITS-1:0] white_level;
        logic [CFG_BITS-1:0] black_level;
        logic [CFG_BITS-1:0] red_hue_min;
        logic [CFG_BITS-1:0] magenta_hue_min;
        logic [CFG_BITS-1:0] blue_hue_min;
        logic [CFG_BITS-1:0] cyan_hue_min;
        logic [CFG_BITS-1:0] green_hue_min;
        logic [CFG_BITS-1:0] yellow_hue_min;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        white_level:     16'd49152,
        black_level:     16'd4096,
        red_hue_min:     16'd60075,
        magenta_hue_min: 16'd49152,
        blue_hue_min:    16'd38229,
        cyan_hue_min:    16'd27307,
        green_hue_min:   16'd16384,
        yellow_hue_min:  16'd5461
    };

endpackage
`default_nettype wire

// ===== rtl/rhc_regs.sv =====
`default_nettype none
module rhc_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rhc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [rhc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [rhc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready,
    output rhc_pkg::t_cfg                            o_cfg
);
    import rhc_pkg::*;

    t_cfg                r_cfg;
    t_reg_idx            reg_idx;
    logic [CFG_BITS-1:0] wdata;
    logic [CFG_BITS-1:0] rdata;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign wdata   = pwdata[CFG_BITS-1:0];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_WHITE_LEVEL:     r_cfg.white_level     <= wdata;
                REG_BLACK_LEVEL:     r_cfg.black_level     <= wdata;
                REG_RED_HUE_MIN:     r_cfg.red_hue_min     <= wdata;
                REG_MAGENTA_HUE_MIN: r_cfg.magenta_hue_min <= wdata;
                REG_BLUE_HUE_MIN:    r_cfg.blue_hue_min    <= wdata;
                REG_CYAN_HUE_MIN:    r_cfg.cyan_hue_min    <= wdata;
                REG_GREEN_HUE_MIN:   r_cfg.green_hue_min   <= wdata;
                REG_YELLOW_HUE_MIN:  r_cfg.yellow_hue_min  <= wdata;
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WHITE_LEVEL:     rdata = r_cfg.white_level;
            REG_BLACK_LEVEL:     rdata = r_cfg.black_level;
            REG_RED_HUE_MIN:     rdata = r_cfg.red_hue_min;
            REG_MAGENTA_HUE_MIN: rdata = r_cfg.magenta_hue_min;
            REG_BLUE_HUE_MIN:    rdata = r_cfg.blue_hue_min;
            REG_CYAN_HUE_MIN:    rdata = r_cfg.cyan_hue_min;
            REG_GREEN_HUE_MIN:   rdata = r_cfg.green_hue_min;
            REG_YELLOW_HUE_MIN:  rdata = r_cfg.yellow_hue_min;
            default:             rdata = '0;
        endcase
    end

    assign prdata = APB_DATA_BITS'(rdata);
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/rhc_prep.sv =====
`default_nettype none
module rhc_prep #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [rhc_pkg::IN_TDATA_BITS-1:0] i_tdata,
    output logic                                   o_valid,
    output logic      [CHANNEL_BITS+2:0]           o_num,
    output logic      [CHANNEL_BITS+2:0]           o_den,
    output logic      [CHANNEL_BITS:0]             o_light
);
    import rhc_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int DW = CB + 3;
    localparam int NW = CB + 4;

    logic [CB-1:0] red, green, blue, mx, mn;
    t_sector       sec;

    logic          r_v1;
    logic [CB-1:0] r_red, r_green, r_blue, r_mx, r_mn;
    t_sector       r_sec;

    logic                 r_v2;
    logic [DW-1:0]        r_num, r_den;
    logic [CB:0]          r_light;

    logic [CB-1:0]        d;
    logic [DW-1:0]        six_d;
    logic signed [NW-1:0] n;
    logic [DW-1:0]        num, den;

    // stage 1: extremes and winning sector
    assign red   = i_tdata[CB-1:0];
    assign green = i_tdata[FIELD_BITS+CB-1:FIELD_BITS];
    assign blue  = i_tdata[2*FIELD_BITS+CB-1:2*FIELD_BITS];

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        // ties: blue over green over red
        priority if (blue == mx) sec = SEC_BLUE;
        else if (green == mx)    sec = SEC_GREEN;
        else                     sec = SEC_RED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= red;
            r_green <= green;
            r_blue  <= blue;
            r_mx    <= mx;
            r_mn    <= mn;
            r_sec   <= sec;
        end
    end

    // stage 2: sector numerator over 6*spread
    assign d     = r_mx - r_mn;
    assign six_d = (DW'(d) << 2) + (DW'(d) << 1);

    always_comb begin
        unique case (r_sec)
            SEC_BLUE:  n = signed'(NW'(DW'(d) << 2)) + signed'(NW'(r_red))
                           - signed'(NW'(r_green));
            SEC_GREEN: n = signed'(NW'(DW'(d) << 1)) + signed'(NW'(r_blue))
                           - signed'(NW'(r_red));
            SEC_RED:   n = signed'(NW'(r_green)) - signed'(NW'(r_blue));
            default:   n = '0;
        endcase
        // wrap negative red hue into one turn
        if (n < 0) n = n + signed'(NW'(six_d));
        if (d == '0) begin
            // zero spread: numerator 0 under an all-ones divisor yields 0
            num = '0;
            den = '1;
        end else begin
            num = n[DW-1:0];
            den = six_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= num;
            r_den   <= den;
            r_light <= (CB+1)'(r_mx) + (CB+1)'(r_mn);
        end
    end

    assign o_valid = r_v2;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_light = r_light;

endmodule
`default_nettype wire

// ===== rtl/rhc_div_stage.sv =====
`default_nettype none
module rhc_div_stage #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [CHANNEL_BITS+2:0]      i_rem,
    input  wire logic [CHANNEL_BITS+2:0]      i_den,
    input  wire logic [rhc_pkg::HUE_BITS-1:0] i_quo,
    input  wire logic [CHANNEL_BITS:0]        i_light,
    output logic                              o_valid,
    output logic      [CHANNEL_BITS+2:0]      o_rem,
    output logic      [CHANNEL_BITS+2:0]      o_den,
    output logic      [rhc_pkg::HUE_BITS-1:0] o_quo,
    output logic      [CHANNEL_BITS:0]        o_light
);
    import rhc_pkg::*;

    localparam int DW = CHANNEL_BITS + 3;

    logic [DW-1:0]       rem;
    logic [DW:0]         t;
    logic [HUE_BITS-1:0] quo;

    logic                r_valid;
    logic [DW-1:0]       r_rem, r_den;
    logic [HUE_BITS-1:0] r_quo;
    logic [CHANNEL_BITS:0] r_light;

    // restoring division, two quotient bits per stage
    always_comb begin
        rem = i_rem;
        quo = i_quo;
        t   = '0;
        for (int k = 0; k < QUO_STEP_BITS; k++) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, i_den}) begin
                t   = t - {1'b0, i_den};
                quo = {quo[HUE_BITS-2:0], 1'b1};
            end else begin
                quo = {quo[HUE_BITS-2:0], 1'b0};
            end
            rem = t[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= rem;
            r_den   <= i_den;
            r_quo   <= quo;
            r_light <= i_light;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_light = r_light;

endmodule
`default_nettype wire

// ===== rtl/rhc_classify.sv =====
`default_nettype none
module rhc_classify #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic [rhc_pkg::HUE_BITS-1:0]       i_hue,
    input  wire logic [CHANNEL_BITS:0]              i_light,
    input  wire rhc_pkg::t_cfg                      i_cfg,
    output logic                                    o_valid,
    output logic      [rhc_pkg::OUT_TDATA_BITS-1:0] o_tdata
);
    import rhc_pkg::*;

    logic [LIGHT_BITS-1:0] light;
    t_class                cls;

    logic                  r_valid;
    logic [HUE_BITS-1:0]   r_hue;
    logic [LIGHT_BITS-1:0] r_light;
    t_class                r_cls;

    assign light = LIGHT_BITS'(i_light);

    always_comb begin
        priority if (light > {i_cfg.white_level, 1'b0}) cls = CLS_WHITE;
        else if (light < {i_cfg.black_level, 1'b0})     cls = CLS_BLACK;
        else if (i_hue > i_cfg.red_hue_min)             cls = CLS_RED;
        else if (i_hue > i_cfg.magenta_hue_min)         cls = CLS_MAGENTA;
        else if (i_hue > i_cfg.blue_hue_min)            cls = CLS_BLUE;
        else if (i_hue > i_cfg.cyan_hue_min)            cls = CLS_CYAN;
        else if (i_hue > i_cfg.green_hue_min)           cls = CLS_GREEN;
        else if (i_hue > i_cfg.yellow_hue_min)          cls = CLS_YELLOW;
        else                                            cls = CLS_RED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue   <= i_hue;
            r_light <= light;
            r_cls   <= cls;
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = OUT_TDATA_BITS'({r_cls, r_light, r_hue});

endmodule
`default_nettype wire

// ===== rtl/rgb_hue_color_classifier_core.sv =====
// rgb hue color classifier: takes one rgb sample per item and returns its hsv hue as a
// 16-bit fraction of a turn, its lightness (max + min channel) and one of eight color
// classes (white, black, red, magenta, blue, cyan, green, yellow). white and black are
// decided by lightness against twice the level registers, otherwise the hue is checked
// against six thresholds from red down to yellow, strictly, with red as fallback.
// the block takes one item every cycle unless the output stalls; each item passes eleven
// register stages: one for max/min, one for the sector numerator, eight divider stages
// retiring two quotient bits each, and the classify/output register. the whole pipeline
// advances together whenever the output register is empty or being taken, so a stall at
// the output holds every stage in place. thresholds are set over the apb port and should
// only change while no item is in flight.
`default_nettype none
module rgb_hue_color_classifier_core #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave side, tdata: red [15:0], green [31:16], blue [47:32]
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [rhc_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // master side, tdata: hue_turn [15:0], lightness_x2 [32:16], color_class [35:33], zeros
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic      [rhc_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    // config port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rhc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [rhc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [rhc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready
);
    import rhc_pkg::*;

    localparam int DW = CHANNEL_BITS + 3;

    t_cfg cfg;
    logic en;

    // divider chain taps, index 0 is the prep output
    logic                    div_valid [DIV_STAGES+1];
    logic [DW-1:0]           div_rem   [DIV_STAGES+1];
    logic [DW-1:0]           div_den   [DIV_STAGES+1];
    logic [HUE_BITS-1:0]     div_quo   [DIV_STAGES+1];
    logic [CHANNEL_BITS:0]   div_light [DIV_STAGES+1];

    // global advance: the output register is free or being drained
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    rhc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rhc_prep #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_tdata (i_s_axis_tdata),
        .o_valid (div_valid[0]),
        .o_num   (div_rem[0]),
        .o_den   (div_den[0]),
        .o_light (div_light[0])
    );

    // quotient starts empty; the numerator is always below the divisor
    assign div_quo[0] = '0;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rhc_div_stage #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[s]),
            .i_rem   (div_rem[s]),
            .i_den   (div_den[s]),
            .i_quo   (div_quo[s]),
            .i_light (div_light[s]),
            .o_valid (div_valid[s+1]),
            .o_rem   (div_rem[s+1]),
            .o_den   (div_den[s+1]),
            .o_quo   (div_quo[s+1]),
            .o_light (div_light[s+1])
        );
    end

    // final remainder and divisor are dropped, only the quotient matters
    rhc_classify #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid[DIV_STAGES]),
        .i_hue   (div_quo[DIV_STAGES]),
        .i_light (div_light[DIV_STAGES]),
        .i_cfg   (cfg),
        .o_valid (o_m_axis_tvalid),
        .o_tdata (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/rhc_checker.sv =====
`default_nettype none
module rhc_assertions #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_s_axis_tready,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready,
    input wire logic [rhc_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    input wire logic [rhc_pkg::APB_DATA_BITS-1:0]  prdata
);
    import rhc_pkg::*;

    localparam logic [LIGHT_BITS-1:0] LIGHT_MAX =
        LIGHT_BITS'(2 * ((1 << CHANNEL_BITS) - 1));

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // after reset the pipeline is empty and ready for items
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

    // lightness cannot exceed twice the largest channel value
    a_light_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[32:16] <= LIGHT_MAX)
        else $error("lightness out of range");

    // padding and unused read bits stay zero
    a_zero_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid |-> o_m_axis_tdata[OUT_TDATA_BITS-1:36] == '0)
        && prdata[APB_DATA_BITS-1:CFG_BITS] == '0)
        else $error("nonzero padding bits");

endmodule

bind rgb_hue_color_classifier_core rhc_assertions #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rhc_assertions (.*);
`default_nettype wire
